FILE: sv/tsq_pkg.sv
`default_nettype none

package tsq_pkg;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_POLL    = 2'd1,
        OP_DONE    = 2'd2
    } op_t;

    localparam int MSG_W   = 40;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;
    localparam int DELAY_W = 16;
    localparam int REP_W   = 8;
    localparam int COUNT_W = 4;

    // input beat layout
    localparam int IN_BYTES_LSB = 0;
    localparam int IN_KIND_LSB  = IN_BYTES_LSB + MSG_W;
    localparam int IN_DELAY_LSB = IN_KIND_LSB + KIND_W;
    localparam int IN_REP_LSB   = IN_DELAY_LSB + DELAY_W;
    localparam int IN_NOW_LSB   = IN_REP_LSB + REP_W;
    localparam int IN_USED_W    = IN_NOW_LSB + TIME_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic [MSG_W-1:0]  msg_bytes;
        logic [TIME_W-1:0] due;
        logic [KIND_W-1:0] kind;
        logic [REP_W-1:0]  repeats;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               busy_res;
        logic               first_send;
        logic [KIND_W-1:0]  sent_type;
        logic [MSG_W-1:0]   sent_bytes;
        logic               sent;
        logic               accepted;
    } result_t;

    localparam int OUT_USED_W  = $bits(result_t);
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: sv/timed_send_queue.sv
// Timed send queue: a ring of up to QUEUE_SLOTS-1 outgoing five-byte messages kept sorted by
// due time (now_time + send_delay) in one single-port-write, registered-read slot memory.
// Each input beat carries an op in tuser. An enqueue walks down from the tail, moving each
// later-due entry up one slot per cycle, then writes the new entry into the freed slot. A
// poll that finds the queue non-empty and idle reads the head slot and checks its due time;
// a due entry is sent and written back with the decremented repeat count, or taken off the
// queue once that count runs out. Done, the unused op, a refused enqueue and a poll on an
// empty or busy queue go straight to the result stage. Every input beat gives exactly one
// output beat; a finished result waits in the output register, and the next input beat is
// taken once the current one has been handed to that register. Slot contents need no
// clearing after reset; head, tail and the pending flag start at zero.

`default_nettype none

module timed_send_queue #(
    parameter int QUEUE_SLOTS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // op
    input  wire logic [1:0]                       s_axis_tuser,
    // message_bytes, message_type, send_delay, repeat_count, now_time
    input  wire logic [tsq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // accepted, sent, sent_bytes, sent_type, first_send, busy_res, entry_count
    output logic      [tsq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready
);

    import tsq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_SLOTS);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_ENQ_RD   = 7'b0000010,
        ST_SHIFT    = 7'b0000100,
        ST_ENQ_PUT  = 7'b0001000,
        ST_POLL_RD  = 7'b0010000,
        ST_POLL_CHK = 7'b0100000,
        ST_FIN      = 7'b1000000
    } state_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_SLOTS - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0) begin
            res = IDX_W'(QUEUE_SLOTS - 1);
        end else begin
            res = idx - IDX_W'(1);
        end
        return res;
    endfunction

    state_t state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic pending_reg, pending_next;
    logic started_reg, started_next;
    slot_t new_reg, new_next;
    logic [TIME_W-1:0] now_reg, now_next;
    result_t res_reg, res_next;
    logic [OUT_TDATA_W-1:0] out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    slot_t ram_wdata, ram_rdata;
    logic [SLOT_W-1:0] ram_rd_bits;

    logic [CNT_W-1:0] fill;
    logic [CNT_W+COUNT_W-1:0] fill_ext;
    logic [REP_W:0] left;
    result_t res_final;

    tsq_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(QUEUE_SLOTS)
    ) u_slots (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rd_bits)
    );

    assign ram_rdata = slot_t'(ram_rd_bits);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tdata = out_reg;
    assign m_axis_tvalid = out_valid_reg;

    // decremented at one extra bit so that the most negative count does not wrap
    assign left = {ram_rdata.repeats[REP_W-1], ram_rdata.repeats} - (REP_W + 1)'(1);

    always_comb begin
        if (tail_reg >= head_reg) begin
            fill = {1'b0, tail_reg} - {1'b0, head_reg};
        end else begin
            fill = {1'b0, tail_reg} + CNT_W'(QUEUE_SLOTS) - {1'b0, head_reg};
        end
        fill_ext = (CNT_W + COUNT_W)'(fill);
    end

    always_comb begin
        res_final = res_reg;
        res_final.busy_res = pending_reg;
        res_final.entry_count = fill_ext[COUNT_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        pos_next = pos_reg;
        pending_next = pending_reg;
        started_next = started_reg;
        new_next = new_reg;
        now_next = now_reg;
        res_next = res_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        ram_we = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = new_reg;
        ram_raddr = prev_idx(pos_reg);

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    new_next.msg_bytes = s_axis_tdata[IN_BYTES_LSB +: MSG_W];
                    new_next.kind = s_axis_tdata[IN_KIND_LSB +: KIND_W];
                    new_next.repeats = s_axis_tdata[IN_REP_LSB +: REP_W];
                    new_next.due = s_axis_tdata[IN_NOW_LSB +: TIME_W]
                                 + TIME_W'(s_axis_tdata[IN_DELAY_LSB +: DELAY_W]);
                    now_next = s_axis_tdata[IN_NOW_LSB +: TIME_W];
                    res_next = '0;
                    state_next = ST_FIN;
                    unique case (op_t'(s_axis_tuser))
                        OP_ENQUEUE: begin
                            if (next_idx(tail_reg) != head_reg) begin
                                res_next.accepted = 1'b1;
                                tail_next = next_idx(tail_reg);
                                pos_next = tail_reg;
                                if (tail_reg == head_reg) begin
                                    state_next = ST_ENQ_PUT;
                                end else begin
                                    state_next = ST_ENQ_RD;
                                end
                            end
                        end
                        OP_POLL: begin
                            if (!pending_reg && head_reg != tail_reg) begin
                                state_next = ST_POLL_RD;
                            end
                        end
                        OP_DONE: begin
                            pending_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENQ_RD: begin
                ram_raddr = prev_idx(pos_reg);
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                // read data is the slot just below pos; fetch the next one down meanwhile
                ram_we = 1'b1;
                ram_waddr = pos_reg;
                ram_raddr = prev_idx(prev_idx(pos_reg));
                if (new_reg.due >= ram_rdata.due) begin
                    ram_wdata = new_reg;
                    state_next = ST_FIN;
                end else begin
                    ram_wdata = ram_rdata;
                    pos_next = prev_idx(pos_reg);
                    if (prev_idx(pos_reg) == head_reg) begin
                        state_next = ST_ENQ_PUT;
                    end
                end
            end
            ST_ENQ_PUT: begin
                ram_we = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = new_reg;
                state_next = ST_FIN;
            end
            ST_POLL_RD: begin
                ram_raddr = head_reg;
                state_next = ST_POLL_CHK;
            end
            ST_POLL_CHK: begin
                if (ram_rdata.due <= now_reg) begin
                    res_next.sent = 1'b1;
                    res_next.sent_bytes = ram_rdata.msg_bytes;
                    res_next.sent_type = ram_rdata.kind;
                    res_next.first_send = !started_reg;
                    pending_next = 1'b1;
                    if (left[REP_W]) begin
                        head_next = next_idx(head_reg);
                        started_next = 1'b0;
                    end else begin
                        ram_we = 1'b1;
                        ram_waddr = head_reg;
                        ram_wdata = ram_rdata;
                        ram_wdata.repeats = left[REP_W-1:0];
                        started_next = 1'b1;
                    end
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_next = OUT_TDATA_W'(res_final);
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            pending_reg <= 1'b0;
            started_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            pending_reg <= pending_next;
            started_reg <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        new_reg <= new_next;
        now_reg <= now_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

FILE: sv/tsq_ram.sv
`default_nettype none

module tsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
